// ===== hw/rtl/pjm_pkg.sv =====
// ----------------------------------------------------------------------------
// pjm_pkg: shared definitions for the period jitter execution monitor
// Event codes, field widths and the request and response types of the divider.
// ----------------------------------------------------------------------------
package pjm_pkg;

  localparam int unsigned StampW  = 32;
  localparam int unsigned CountW  = 32;
  localparam int unsigned SumW    = 64;
  localparam int unsigned FracW   = 8;
  localparam int unsigned AvgW    = StampW + FracW;
  localparam int unsigned ModeW   = 2;

  // The divider resumes after the upper half of the sum, so it only steps
  // through the lower half and the fraction bits.
  localparam int unsigned DivSteps = StampW + FracW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [StampW-1:0] ExpectedPeriodReset = 32'd1000;

  localparam logic [ModeW-1:0] ModeStart  = 2'd0;
  localparam logic [ModeW-1:0] ModeEnd    = 2'd1;
  localparam logic [ModeW-1:0] ModeReport = 2'd2;
  localparam logic [ModeW-1:0] ModeReset  = 2'd3;

  typedef struct packed {
    logic              go;
    logic [StampW-1:0] rem_init;     // upper half of the sum
    logic [StampW-1:0] dividend_lo;  // lower half of the sum
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [AvgW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/pjm_div.sv =====
// ----------------------------------------------------------------------------
// pjm_div: radix-2 restoring divider for fixed-point averages
// Computes floor(sum * 256 / count) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pjm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pjm_pkg::div_req_t req_i,
  output pjm_pkg::div_rsp_t rsp_o
);

  logic [pjm_pkg::StampW-1:0]  rem_q, rem_d;
  logic [pjm_pkg::AvgW-1:0]    quo_q, quo_d;
  logic [pjm_pkg::CountW-1:0]  dvs_q, dvs_d;
  logic [pjm_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  logic [pjm_pkg::StampW:0] rem_sh;
  logic [pjm_pkg::StampW:0] rem_sub;
  logic                     ge;

  // The remainder always stays below the divisor, so one extra bit suffices.
  assign rem_sh  = {rem_q, quo_q[pjm_pkg::AvgW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.go) begin
      rem_d  = req_i.rem_init;
      quo_d  = {req_i.dividend_lo, {pjm_pkg::FracW{1'b0}}};
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[pjm_pkg::StampW-1:0] : rem_sh[pjm_pkg::StampW-1:0];
      quo_d = {quo_q[pjm_pkg::AvgW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pjm_pkg::DivCntW'(pjm_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ===== hw/rtl/period_jitter_exec_monitor_top.sv =====
// A measured start passes through StMeas, StJit and StUpd to StFin, a measured end through
// StMeas and StUpd to StFin, and a first start or a dropped sample goes straight to StFin.
// A report event goes through StDrain, three passes of the shared radix-2 divider, one per
// average, StRepFin and StFin; a reset event through StDrain to StFin. Both wait for a free output.
// One event is in flight at a time; a finished result may wait in the output
// register while the next event is accepted.
// Reset clears all statistics and the report and sets the expected period to 1000.
// ----------------------------------------------------------------------------
// period_jitter_exec_monitor_top: periodic task period and jitter monitor
// Collects period, jitter and execution time statistics from timestamped
// events and returns the latched report after every event.
// ----------------------------------------------------------------------------
module period_jitter_exec_monitor_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,  // now_stamp[31:0], start_stamp[63:32]
  input  logic [1:0]    s_axis_tuser,  // mode[1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // rep_samples[31:0], rep_min_period[63:32], rep_max_period[95:64],
  // rep_avg_period[135:96], rep_max_jitter[167:136], rep_avg_jitter[207:168],
  // rep_min_exec[239:208], rep_max_exec[271:240], rep_avg_exec[311:272],
  // rep_overruns[343:312]
  output logic [343:0]  m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [31:0]   cfg_data_i
);

  localparam int unsigned SW = pjm_pkg::StampW;
  localparam int unsigned CW = pjm_pkg::CountW;
  localparam int unsigned MW = pjm_pkg::SumW;
  localparam int unsigned AW = pjm_pkg::AvgW;

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StMeas    = 4'd1;
  localparam logic [3:0] StJit     = 4'd2;
  localparam logic [3:0] StUpd     = 4'd3;
  localparam logic [3:0] StDrain   = 4'd4;
  localparam logic [3:0] StDivGo   = 4'd5;
  localparam logic [3:0] StDivWait = 4'd6;
  localparam logic [3:0] StRepFin  = 4'd7;
  localparam logic [3:0] StFin     = 4'd8;

  localparam logic [1:0] SelPeriod = 2'd0;
  localparam logic [1:0] SelJitter = 2'd1;
  localparam logic [1:0] SelExec   = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic       m_valid_q, m_valid_d;

  logic [pjm_pkg::ModeW-1:0] mode_q, mode_d;
  logic [SW-1:0] now_q, now_d, st_q, st_d, meas_q, meas_d, jit_q, jit_d;

  logic [SW-1:0] expected_q, expected_d;
  logic          have_last_q, have_last_d;
  logic [SW-1:0] last_start_q, last_start_d;
  logic [CW-1:0] period_count_q, period_count_d;
  logic [SW-1:0] min_period_q, min_period_d, max_period_q, max_period_d;
  logic [SW-1:0] max_jitter_q, max_jitter_d;
  logic [MW-1:0] sum_period_q, sum_period_d, sum_jitter_q, sum_jitter_d;
  logic [CW-1:0] exec_count_q, exec_count_d;
  logic [SW-1:0] min_exec_q, min_exec_d, max_exec_q, max_exec_d;
  logic [MW-1:0] sum_exec_q, sum_exec_d;
  logic [CW-1:0] overrun_q, overrun_d;

  logic [CW-1:0] rep_samples_q, rep_samples_d;
  logic [SW-1:0] rep_min_period_q, rep_min_period_d, rep_max_period_q, rep_max_period_d;
  logic [AW-1:0] rep_avg_period_q, rep_avg_period_d;
  logic [SW-1:0] rep_max_jitter_q, rep_max_jitter_d;
  logic [AW-1:0] rep_avg_jitter_q, rep_avg_jitter_d;
  logic [SW-1:0] rep_min_exec_q, rep_min_exec_d, rep_max_exec_q, rep_max_exec_d;
  logic [AW-1:0] rep_avg_exec_q, rep_avg_exec_d;
  logic [CW-1:0] rep_overruns_q, rep_overruns_d;

  pjm_pkg::div_req_t div_req;
  pjm_pkg::div_rsp_t div_rsp;

  logic in_fire;
  logic out_free;
  logic has_period;
  logic has_exec;

  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign has_period    = (period_count_q != '0);
  assign has_exec      = (exec_count_q != '0);

  always_comb begin
    div_req.go = (state_q == StDivGo);
    case (sel_q)
      SelPeriod: begin
        div_req.rem_init    = sum_period_q[MW-1:SW];
        div_req.dividend_lo = sum_period_q[SW-1:0];
        div_req.divisor     = period_count_q;
      end
      SelJitter: begin
        div_req.rem_init    = sum_jitter_q[MW-1:SW];
        div_req.dividend_lo = sum_jitter_q[SW-1:0];
        div_req.divisor     = period_count_q;
      end
      default: begin
        div_req.rem_init    = sum_exec_q[MW-1:SW];
        div_req.dividend_lo = sum_exec_q[SW-1:0];
        div_req.divisor     = exec_count_q;
      end
    endcase
  end

  pjm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d          = state_q;
    sel_d            = sel_q;
    m_valid_d        = m_valid_q;
    mode_d           = mode_q;
    now_d            = now_q;
    st_d             = st_q;
    meas_d           = meas_q;
    jit_d            = jit_q;
    expected_d       = expected_q;
    have_last_d      = have_last_q;
    last_start_d     = last_start_q;
    period_count_d   = period_count_q;
    min_period_d     = min_period_q;
    max_period_d     = max_period_q;
    max_jitter_d     = max_jitter_q;
    sum_period_d     = sum_period_q;
    sum_jitter_d     = sum_jitter_q;
    exec_count_d     = exec_count_q;
    min_exec_d       = min_exec_q;
    max_exec_d       = max_exec_q;
    sum_exec_d       = sum_exec_q;
    overrun_d        = overrun_q;
    rep_samples_d    = rep_samples_q;
    rep_min_period_d = rep_min_period_q;
    rep_max_period_d = rep_max_period_q;
    rep_avg_period_d = rep_avg_period_q;
    rep_max_jitter_d = rep_max_jitter_q;
    rep_avg_jitter_d = rep_avg_jitter_q;
    rep_min_exec_d   = rep_min_exec_q;
    rep_max_exec_d   = rep_max_exec_q;
    rep_avg_exec_d   = rep_avg_exec_q;
    rep_overruns_d   = rep_overruns_q;

    if (cfg_valid_i) begin
      expected_d = cfg_data_i;
    end

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          mode_d = s_axis_tuser;
          now_d  = s_axis_tdata[SW-1:0];
          st_d   = s_axis_tdata[2*SW-1:SW];
          case (s_axis_tuser)
            pjm_pkg::ModeStart: begin
              if (have_last_q && (period_count_q != '1)) begin
                state_d = StMeas;
              end else begin
                // First start or saturated count: only the stamp moves on.
                last_start_d = s_axis_tdata[SW-1:0];
                have_last_d  = 1'b1;
                state_d      = StFin;
              end
            end
            pjm_pkg::ModeEnd: begin
              state_d = (exec_count_q != '1) ? StMeas : StFin;
            end
            default: begin
              state_d = StDrain;
            end
          endcase
        end
      end
      StMeas: begin
        if (mode_q == pjm_pkg::ModeEnd) begin
          meas_d  = now_q - st_q;
          state_d = StUpd;
        end else begin
          meas_d  = now_q - last_start_q;
          state_d = StJit;
        end
      end
      StJit: begin
        jit_d   = (meas_q > expected_q) ? (meas_q - expected_q) : (expected_q - meas_q);
        state_d = StUpd;
      end
      StUpd: begin
        if (mode_q == pjm_pkg::ModeEnd) begin
          exec_count_d = exec_count_q + 1'b1;
          if (meas_q < min_exec_q) min_exec_d = meas_q;
          if (meas_q > max_exec_q) max_exec_d = meas_q;
          sum_exec_d = sum_exec_q + MW'(meas_q);
          if (meas_q > expected_q) overrun_d = overrun_q + 1'b1;
        end else begin
          period_count_d = period_count_q + 1'b1;
          if (meas_q < min_period_q) min_period_d = meas_q;
          if (meas_q > max_period_q) max_period_d = meas_q;
          if (jit_q > max_jitter_q) max_jitter_d = jit_q;
          sum_period_d = sum_period_q + MW'(meas_q);
          sum_jitter_d = sum_jitter_q + MW'(jit_q);
          last_start_d = now_q;
          have_last_d  = 1'b1;
        end
        state_d = StFin;
      end
      StDrain: begin
        // The report registers drive the output, so they change only once
        // the previous result has left.
        if (out_free) begin
          if (mode_q == pjm_pkg::ModeReset) begin
            have_last_d      = 1'b0;
            last_start_d     = '0;
            period_count_d   = '0;
            min_period_d     = '1;
            max_period_d     = '0;
            max_jitter_d     = '0;
            sum_period_d     = '0;
            sum_jitter_d     = '0;
            exec_count_d     = '0;
            min_exec_d       = '1;
            max_exec_d       = '0;
            sum_exec_d       = '0;
            overrun_d        = '0;
            rep_samples_d    = '0;
            rep_min_period_d = '0;
            rep_max_period_d = '0;
            rep_avg_period_d = '0;
            rep_max_jitter_d = '0;
            rep_avg_jitter_d = '0;
            rep_min_exec_d   = '0;
            rep_max_exec_d   = '0;
            rep_avg_exec_d   = '0;
            rep_overruns_d   = '0;
            state_d          = StFin;
          end else begin
            sel_d   = SelPeriod;
            state_d = StDivGo;
          end
        end
      end
      StDivGo: begin
        state_d = StDivWait;
      end
      StDivWait: begin
        if (div_rsp.done) begin
          case (sel_q)
            SelPeriod: begin
              rep_avg_period_d = has_period ? div_rsp.quot : '0;
              sel_d            = SelJitter;
              state_d          = StDivGo;
            end
            SelJitter: begin
              rep_avg_jitter_d = has_period ? div_rsp.quot : '0;
              sel_d            = SelExec;
              state_d          = StDivGo;
            end
            default: begin
              rep_avg_exec_d = has_exec ? div_rsp.quot : '0;
              state_d        = StRepFin;
            end
          endcase
        end
      end
      StRepFin: begin
        rep_samples_d    = period_count_q;
        rep_min_period_d = has_period ? min_period_q : '0;
        rep_max_period_d = has_period ? max_period_q : '0;
        rep_max_jitter_d = has_period ? max_jitter_q : '0;
        rep_min_exec_d   = has_exec ? min_exec_q : '0;
        rep_max_exec_d   = has_exec ? max_exec_q : '0;
        rep_overruns_d   = overrun_q;
        period_count_d   = '0;
        min_period_d     = '1;
        max_period_d     = '0;
        max_jitter_d     = '0;
        sum_period_d     = '0;
        sum_jitter_d     = '0;
        exec_count_d     = '0;
        min_exec_d       = '1;
        max_exec_d       = '0;
        sum_exec_d       = '0;
        overrun_d        = '0;
        state_d          = StFin;
      end
      StFin: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= StIdle;
      sel_q            <= SelPeriod;
      m_valid_q        <= 1'b0;
      expected_q       <= pjm_pkg::ExpectedPeriodReset;
      have_last_q      <= 1'b0;
      last_start_q     <= '0;
      period_count_q   <= '0;
      min_period_q     <= '1;
      max_period_q     <= '0;
      max_jitter_q     <= '0;
      sum_period_q     <= '0;
      sum_jitter_q     <= '0;
      exec_count_q     <= '0;
      min_exec_q       <= '1;
      max_exec_q       <= '0;
      sum_exec_q       <= '0;
      overrun_q        <= '0;
      rep_samples_q    <= '0;
      rep_min_period_q <= '0;
      rep_max_period_q <= '0;
      rep_avg_period_q <= '0;
      rep_max_jitter_q <= '0;
      rep_avg_jitter_q <= '0;
      rep_min_exec_q   <= '0;
      rep_max_exec_q   <= '0;
      rep_avg_exec_q   <= '0;
      rep_overruns_q   <= '0;
    end else begin
      state_q          <= state_d;
      sel_q            <= sel_d;
      m_valid_q        <= m_valid_d;
      expected_q       <= expected_d;
      have_last_q      <= have_last_d;
      last_start_q     <= last_start_d;
      period_count_q   <= period_count_d;
      min_period_q     <= min_period_d;
      max_period_q     <= max_period_d;
      max_jitter_q     <= max_jitter_d;
      sum_period_q     <= sum_period_d;
      sum_jitter_q     <= sum_jitter_d;
      exec_count_q     <= exec_count_d;
      min_exec_q       <= min_exec_d;
      max_exec_q       <= max_exec_d;
      sum_exec_q       <= sum_exec_d;
      overrun_q        <= overrun_d;
      rep_samples_q    <= rep_samples_d;
      rep_min_period_q <= rep_min_period_d;
      rep_max_period_q <= rep_max_period_d;
      rep_avg_period_q <= rep_avg_period_d;
      rep_max_jitter_q <= rep_max_jitter_d;
      rep_avg_jitter_q <= rep_avg_jitter_d;
      rep_min_exec_q   <= rep_min_exec_d;
      rep_max_exec_q   <= rep_max_exec_d;
      rep_avg_exec_q   <= rep_avg_exec_d;
      rep_overruns_q   <= rep_overruns_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    now_q  <= now_d;
    st_q   <= st_d;
    meas_q <= meas_d;
    jit_q  <= jit_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {rep_overruns_q, rep_avg_exec_q, rep_max_exec_q, rep_min_exec_q,
                          rep_avg_jitter_q, rep_max_jitter_q, rep_avg_period_q,
                          rep_max_period_q, rep_min_period_q, rep_samples_q};

endmodule
